>>> rtl/rpsp_pkg.sv
// Shared types, opcode constants and field widths for the RISC-V predecoder.
package rpsp_pkg;

	localparam int unsigned XLEN       = 32;
	localparam int unsigned REG_IDX_W  = 5;
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 80;

	localparam logic [6:0] OPC_BRANCH    = 7'h63;
	localparam logic [6:0] OPC_JAL       = 7'h6f;
	localparam logic [6:0] OPC_JALR      = 7'h67;
	localparam logic [6:0] OPC_OP        = 7'h33;
	localparam logic [6:0] FUNCT7_MULDIV = 7'h01;
	localparam logic [1:0] QUAD_32BIT    = 2'b11;

	typedef enum logic {
		CMD_PREDECODE = 1'b0,
		CMD_FLUSH     = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		MD_MUL    = 3'd0,
		MD_MULH   = 3'd1,
		MD_MULHSU = 3'd2,
		MD_MULHU  = 3'd3,
		MD_DIV    = 3'd4,
		MD_DIVU   = 3'd5,
		MD_REM    = 3'd6,
		MD_REMU   = 3'd7
	} md_kind_t;

	// Multiply/divide description of the instruction in the decode stage.
	typedef struct packed {
		logic                  is_md;
		md_kind_t              kind;
		logic [REG_IDX_W-1:0]  rs1;
		logic [REG_IDX_W-1:0]  rs2;
		logic [REG_IDX_W-1:0]  rd;
	} md_info_t;

	// History update control from the decode stage.
	typedef struct packed {
		logic en;
		logic flush;
	} hist_upd_t;

	function automatic logic kinds_pair(md_kind_t cur, md_kind_t prev);
		logic r;
		r = (cur == MD_MUL && (prev == MD_MULH || prev == MD_MULHSU || prev == MD_MULHU))
			|| (cur == MD_DIV && prev == MD_REM)
			|| (cur == MD_REM && prev == MD_DIV)
			|| (cur == MD_DIVU && prev == MD_REMU)
			|| (cur == MD_REMU && prev == MD_DIVU);
		return r;
	endfunction

endpackage

>>> rtl/rpsp_decode.sv
// Combinational predecode: size, register fields, immediates and static prediction.
module rpsp_decode (
	input  logic [rpsp_pkg::XLEN-1:0]      pc,
	input  logic [rpsp_pkg::XLEN-1:0]      instr_word,
	output logic [rpsp_pkg::XLEN-1:0]      instr_out,
	output logic                           is_32bit,
	output logic [rpsp_pkg::REG_IDX_W-1:0] rs1_index,
	output logic [rpsp_pkg::REG_IDX_W-1:0] rs2_index,
	output logic                           predicted_taken,
	output logic [rpsp_pkg::XLEN-1:0]      next_pc,
	output rpsp_pkg::md_info_t             md
);
	import rpsp_pkg::*;

	logic [6:0]      opc;
	logic [XLEN-1:0] imm_b;
	logic [XLEN-1:0] imm_j;
	logic [XLEN-1:0] imm_i;
	logic [XLEN-1:0] imm;
	logic [XLEN-1:0] step;

	assign is_32bit  = (instr_word[1:0] == QUAD_32BIT);
	assign opc       = instr_word[6:0];
	assign instr_out = is_32bit ? instr_word : {16'h0000, instr_word[15:0]};
	assign rs1_index = is_32bit ? instr_word[19:15] : '0;
	assign rs2_index = is_32bit ? instr_word[24:20] : '0;

	assign imm_b = {{(XLEN-12){instr_word[31]}}, instr_word[7], instr_word[30:25],
		instr_word[11:8], 1'b0};
	assign imm_j = {{(XLEN-20){instr_word[31]}}, instr_word[19:12], instr_word[20],
		instr_word[30:21], 1'b0};
	assign imm_i = {{(XLEN-12){instr_word[31]}}, instr_word[31:20]};

	always_comb begin
		predicted_taken = 1'b0;
		imm             = imm_i;
		md              = '0;
		if (is_32bit) begin
			case (opc)
				OPC_BRANCH: begin
					imm             = imm_b;
					predicted_taken = instr_word[31];
				end
				OPC_JAL: begin
					imm             = imm_j;
					predicted_taken = 1'b1;
				end
				OPC_JALR: begin
					imm             = imm_i;
					predicted_taken = 1'b1;
				end
				OPC_OP: begin
					md.is_md = (instr_word[31:25] == FUNCT7_MULDIV);
				end
				default: begin
					predicted_taken = 1'b0;
				end
			endcase
		end
		md.kind = md_kind_t'(instr_word[14:12]);
		md.rs1  = instr_word[19:15];
		md.rs2  = instr_word[24:20];
		md.rd   = instr_word[11:7];
	end

	assign step    = is_32bit ? XLEN'(4) : XLEN'(2);
	assign next_pc = pc + (predicted_taken ? imm : step);

endmodule

>>> rtl/rpsp_history.sv
// Last multiply/divide history and back-to-back pair detection.
module rpsp_history (
	input  logic               clk,
	input  logic               arst_n,
	input  rpsp_pkg::md_info_t cur,
	input  rpsp_pkg::hist_upd_t upd,
	output logic               muldiv_pair
);
	import rpsp_pkg::*;

	logic                 valid_q;
	md_kind_t             kind_q;
	logic [REG_IDX_W-1:0] src1_q;
	logic [REG_IDX_W-1:0] src2_q;
	logic [REG_IDX_W-1:0] dest_q;

	assign muldiv_pair = cur.is_md && valid_q && kinds_pair(cur.kind, kind_q)
		&& cur.rs1 == src1_q && cur.rs2 == src2_q
		&& cur.rs1 != dest_q && cur.rs2 != dest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= MD_MUL;
			src1_q  <= '0;
			src2_q  <= '0;
			dest_q  <= '0;
		end else if (upd.en) begin
			if (upd.flush || !cur.is_md) begin
				valid_q <= 1'b0;
				kind_q  <= MD_MUL;
				src1_q  <= '0;
				src2_q  <= '0;
				dest_q  <= '0;
			end else begin
				valid_q <= 1'b1;
				kind_q  <= cur.kind;
				src1_q  <= cur.rs1;
				src2_q  <= cur.rs2;
				dest_q  <= cur.rd;
			end
		end
	end

endmodule

>>> rtl/riscv_predecode_static_predict.sv
// Top level of the fetch-stage predecoder with static branch prediction.
//
// Usage: requests enter on the s_axis channel. tuser carries the command
// (predecode or flush); tdata carries pc, the 32-bit instruction word and the
// bus-error flag. Each predecode request yields one result on m_axis; a flush
// request clears the multiply/divide pairing history and yields no result.
// A request is taken into an input register, decoded by short combinational
// logic and the result is captured in an output register. A result is valid
// on m_axis once the output register holds it, so the request passes the
// input register and the output register before it can be taken.
// One request is accepted every cycle as
// long as results drain; the rate is set by the single decode stage.
// When the receiver stalls, the result holds in the output register and the
// input register still fills, after which s_axis_tready drops until the
// output register is freed. Flush requests never wait on the receiver.
// Reset empties both registers and clears the pairing history.
module riscv_predecode_static_predict (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata from bit 0: pc[31:0], instr_word[31:0], fetch_err, 7 zero bits.
	input  logic [rpsp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// tuser: cmd.
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata from bit 0: instr_out[31:0], is_32bit, fetch_ok, fetch_err_out,
	// misalign, rs1_index[4:0], rs2_index[4:0], predicted_taken,
	// next_pc[31:0], muldiv_pair.
	output logic [rpsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import rpsp_pkg::*;

	// Input stage register.
	logic            valid_s1;
	cmd_t            cmd_s1;
	logic [XLEN-1:0] pc_s1;
	logic [XLEN-1:0] instr_s1;
	logic            berr_s1;

	// Output register.
	logic                  valid_s2;
	logic [OUT_DATA_W-1:0] data_s2;

	logic                 out_free;
	logic                 fire_s1;
	logic                 in_acc;
	logic [XLEN-1:0]      instr_out;
	logic                 is_32bit;
	logic [REG_IDX_W-1:0] rs1_index;
	logic [REG_IDX_W-1:0] rs2_index;
	logic                 predicted_taken;
	logic [XLEN-1:0]      next_pc;
	logic                 muldiv_pair;
	logic                 misalign;
	logic                 fetch_ok;
	md_info_t             md;
	hist_upd_t            upd;

	// The output register can load when it is empty or being drained.
	assign out_free = !valid_s2 || m_axis_tready;
	// A flush retires from the input stage without needing the output register.
	assign fire_s1  = valid_s1 && (cmd_s1 == CMD_FLUSH || out_free);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			pc_s1    <= s_axis_tdata[31:0];
			instr_s1 <= s_axis_tdata[63:32];
			berr_s1  <= s_axis_tdata[64];
		end
	end

	rpsp_decode u_decode (
		.pc              (pc_s1),
		.instr_word      (instr_s1),
		.instr_out       (instr_out),
		.is_32bit        (is_32bit),
		.rs1_index       (rs1_index),
		.rs2_index       (rs2_index),
		.predicted_taken (predicted_taken),
		.next_pc         (next_pc),
		.md              (md)
	);

	// History advances in request order, as each request leaves the input stage.
	assign upd.en    = fire_s1;
	assign upd.flush = (cmd_s1 == CMD_FLUSH);

	rpsp_history u_history (
		.clk         (clk),
		.arst_n      (arst_n),
		.cur         (md),
		.upd         (upd),
		.muldiv_pair (muldiv_pair)
	);

	assign misalign = pc_s1[0];
	assign fetch_ok = !berr_s1 && !misalign;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && cmd_s1 == CMD_PREDECODE) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && cmd_s1 == CMD_PREDECODE) begin
			data_s2 <= {muldiv_pair, next_pc, predicted_taken, rs2_index, rs1_index,
				misalign, berr_s1, fetch_ok, is_32bit, instr_out};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

`ifndef SYNTH
	// The fetch_ok flag of a result agrees with its error and alignment flags.
	a_fetch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33] == !(m_axis_tdata[34] || m_axis_tdata[35]))
		else $error("fetch_ok disagrees with fetch_err_out/misalign");

	// A compressed instruction is never taken, never pairs, has no sources.
	a_compressed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[32]) |->
		(!m_axis_tdata[46] && !m_axis_tdata[79] && m_axis_tdata[45:36] == 10'd0))
		else $error("compressed result carries branch or pair information");

	// An empty input stage always takes a new request.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// A stalled result stays in the output register.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");
`endif

endmodule
